[hw/rtl/bfp_pkg.sv]
// Shared types and constants of the best-fit buffer pool.
package bfp_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int SIZE_W = 48;
  localparam int ID_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 64;
  localparam logic [SIZE_W-1:0] MIN_NEW_SIZE_RESET = SIZE_W'(64 * 1024 * 1024);

  typedef enum logic {
    OP_ALLOC,
    OP_RELEASE
  } op_t;

  typedef enum logic [1:0] {
    ST_REUSED,
    ST_NEW,
    ST_STORED,
    ST_DROPPED
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] amount;
    logic [ID_W-1:0]   buffer_id;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t data;
  } queue_head_t;

endpackage

[hw/rtl/bfp_front.sv]
// Request intake: accepts words, decodes the command and queues them for the pool engine.
module bfp_front import bfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [SIZE_W-1:0] in_amount,
  input  logic [ID_W-1:0]   in_buffer_id,
  output queue_head_t       head,
  input  logic              pop
);

  req_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              push;
  logic              pop_ok;
  req_t              decoded;

  assign busy = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy;
  assign pop_ok = pop && (fill_r != '0);

  always_comb begin
    decoded.op = in_cmd ? OP_RELEASE : OP_ALLOC;
    decoded.amount = in_amount;
    decoded.buffer_id = in_buffer_id;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop_ok) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop_ok && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= decoded;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.data = slot_r[rd_ptr_r];

endmodule

[hw/rtl/bfp_back.sv]
// Pool engine: holds the sorted pool and carries out allocate and release requests.
module bfp_back import bfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  queue_head_t       head,
  output logic              pop,
  input  logic [SIZE_W-1:0] min_new_size,
  output logic              out_valid,
  output status_t           out_status,
  output logic [SIZE_W-1:0] out_granted_size,
  output logic [ID_W-1:0]   out_granted_id
);

  back_state_t       state_r, state_nxt;
  req_t              req_r;
  logic              hit_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] sel_size_r;
  logic [ID_W-1:0]   sel_id_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] pool_size_r [POOL_ENTRIES];
  logic [SIZE_W-1:0] pool_size_nxt [POOL_ENTRIES];
  logic [ID_W-1:0]   pool_id_r [POOL_ENTRIES];
  logic [ID_W-1:0]   pool_id_nxt [POOL_ENTRIES];

  logic [POOL_ENTRIES-1:0] match;
  logic [IDX_W-1:0]        idx_nxt;
  logic                    full;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;

  assign full = (count_r == CNT_W'(POOL_ENTRIES));

  // Parallel compare against every occupied entry; the lowest matching entry wins.
  // With no match, a release lands at the end of the pool.
  always_comb begin
    match = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (CNT_W'(i) < count_r) begin
        if (req_r.op == OP_ALLOC) begin
          match[i] = (pool_size_r[i] >= req_r.amount);
        end else begin
          match[i] = (pool_size_r[i] > req_r.amount);
        end
      end
    end
    idx_nxt = count_r[IDX_W-1:0];
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        idx_nxt = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    for (int k = 0; k < POOL_ENTRIES; k++) begin
      pool_size_nxt[k] = pool_size_r[k];
      pool_id_nxt[k] = pool_id_r[k];
    end
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_size_nxt = out_size_r;
    out_id_nxt = out_id_r;
    if (state_r == S_APPLY) begin
      out_valid_nxt = 1'b1;
      if (req_r.op == OP_ALLOC) begin
        if (hit_r) begin
          // Close the gap left by the taken entry.
          for (int k = 0; k < POOL_ENTRIES - 1; k++) begin
            if (IDX_W'(k) >= idx_r) begin
              pool_size_nxt[k] = pool_size_r[k+1];
              pool_id_nxt[k] = pool_id_r[k+1];
            end
          end
          count_nxt = count_r - 1'b1;
          out_status_nxt = ST_REUSED;
          out_size_nxt = sel_size_r;
          out_id_nxt = sel_id_r;
        end else begin
          out_status_nxt = ST_NEW;
          out_size_nxt = (req_r.amount > min_new_size) ? req_r.amount : min_new_size;
          out_id_nxt = '0;
        end
      end else begin
        out_size_nxt = '0;
        out_id_nxt = '0;
        if (full) begin
          out_status_nxt = ST_DROPPED;
        end else begin
          // Open a slot at the insert point by moving the larger entries up one place.
          for (int k = 1; k < POOL_ENTRIES; k++) begin
            if (IDX_W'(k) > idx_r) begin
              pool_size_nxt[k] = pool_size_r[k-1];
              pool_id_nxt[k] = pool_id_r[k-1];
            end
          end
          pool_size_nxt[idx_r] = req_r.amount;
          pool_id_nxt[idx_r] = req_r.buffer_id;
          count_nxt = count_r + 1'b1;
          out_status_nxt = ST_STORED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_r <= head.data;
    end
    if (state_r == S_SCAN) begin
      hit_r <= |match;
      idx_r <= idx_nxt;
      sel_size_r <= pool_size_r[idx_nxt];
      sel_id_r <= pool_id_r[idx_nxt];
    end
    for (int k = 0; k < POOL_ENTRIES; k++) begin
      pool_size_r[k] <= pool_size_nxt[k];
      pool_id_r[k] <= pool_id_nxt[k];
    end
    out_status_r <= out_status_nxt;
    out_size_r <= out_size_nxt;
    out_id_r <= out_id_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_granted_size = out_size_r;
  assign out_granted_id = out_id_r;

endmodule

[hw/rtl/best_fit_buffer_pool.sv]
// Top level of the best-fit buffer pool: request intake, pool engine and configuration register.
//
//   channel   handshake                        payload
//   input     start / busy                     in_cmd, in_amount, in_buffer_id
//   result    out_valid (one-cycle strobe)     out_status, out_granted_size, out_granted_id
//   config    psel, penable, pwrite, pready    paddr, pwdata, prdata (min_new_size)
//
// Each request passes through the pool engine as fetch from the queue, parallel compare over the
// occupied ones of the sixteen entries, then shift and update; its result strobes the cycle after.
// A two-word queue in front of the engine takes new words while the engine works; busy is
// high only while that queue is full. Reset is synchronous and empties the pool and the queue.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
module best_fit_buffer_pool import bfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [SIZE_W-1:0]  in_amount,
  input  logic [ID_W-1:0]    in_buffer_id,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [SIZE_W-1:0]  out_granted_size,
  output logic [ID_W-1:0]    out_granted_id,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  queue_head_t       head;
  logic              pop;
  status_t           status;
  logic [SIZE_W-1:0] min_new_size_r, min_new_size_nxt;
  logic              cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Only one register exists; every address in the window selects it.
  always_comb begin
    min_new_size_nxt = min_new_size_r;
    if (cfg_write) begin
      min_new_size_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_new_size_r <= MIN_NEW_SIZE_RESET;
    end else begin
      min_new_size_r <= min_new_size_nxt;
    end
  end

  assign prdata = (paddr == '0) ? PDATA_W'(min_new_size_r) : PDATA_W'(min_new_size_r);

  bfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_amount    (in_amount),
    .in_buffer_id (in_buffer_id),
    .head         (head),
    .pop          (pop)
  );

  bfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .min_new_size     (min_new_size_r),
    .out_valid        (out_valid),
    .out_status       (status),
    .out_granted_size (out_granted_size),
    .out_granted_id   (out_granted_id)
  );

  assign out_status = 2'(status);

endmodule

[test/testbench.sv]
// Self-checking testbench of the best-fit buffer pool: directed table, random traffic, register phases.
`timescale 1ns / 1ps

module testbench;
  import bfp_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam int REG_MIN_NEW_SIZE = 0;
  localparam logic [PADDR_W-1:0] ADDR_MIN_NEW_SIZE = PADDR_W'(8 * REG_MIN_NEW_SIZE);
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PHASES = 5;
  localparam int WORDS_PER_PHASE = 100;

  typedef struct packed {
    status_t           status;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } grant_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] amount;
    logic [ID_W-1:0]   id;
    logic              typed;
    grant_t            grant;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_cmd;
  logic [SIZE_W-1:0] in_amount;
  logic [ID_W-1:0]   in_buffer_id;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [SIZE_W-1:0] out_granted_size;
  logic [ID_W-1:0]   out_granted_id;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  // Our own copy of the pool, kept sorted by size like the block's.
  logic [SIZE_W-1:0] pool_sz [POOL_ENTRIES];
  logic [ID_W-1:0]   pool_tag [POOL_ENTRIES];
  int                pool_fill;
  logic [SIZE_W-1:0] model_min_size;

  grant_t    pending_grants[$];
  plan_row_t directed_plan [DIRECTED_ROWS];
  int        errors;
  int        words_sent;
  int        status_seen [4];
  bit        burst;

  best_fit_buffer_pool dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_amount        (in_amount),
    .in_buffer_id     (in_buffer_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_granted_size (out_granted_size),
    .out_granted_id   (out_granted_id),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Applies one request to the pool copy and returns the grant it earns.
  function automatic grant_t pool_apply(op_t op, logic [SIZE_W-1:0] amount,
                                        logic [ID_W-1:0] id);
    grant_t g;
    int     pos;
    bit     found;
    g = '0;
    pos = pool_fill;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < pool_fill; i++) begin
        if (!found && pool_sz[i] >= amount) begin
          found = 1'b1;
          pos = i;
        end
      end
      if (found) begin
        g.status = ST_REUSED;
        g.size = pool_sz[pos];
        g.id = pool_tag[pos];
        for (int k = pos; k < pool_fill - 1; k++) begin
          pool_sz[k] = pool_sz[k + 1];
          pool_tag[k] = pool_tag[k + 1];
        end
        pool_fill--;
      end else begin
        g.status = ST_NEW;
        g.size = (amount > model_min_size) ? amount : model_min_size;
      end
    end else if (pool_fill >= POOL_ENTRIES) begin
      g.status = ST_DROPPED;
    end else begin
      // Equal sizes keep release order: insert ahead of the first strictly larger one.
      for (int i = 0; i < pool_fill; i++) begin
        if (!found && pool_sz[i] > amount) begin
          found = 1'b1;
          pos = i;
        end
      end
      for (int k = pool_fill; k > pos; k--) begin
        pool_sz[k] = pool_sz[k - 1];
        pool_tag[k] = pool_tag[k - 1];
      end
      pool_sz[pos] = amount;
      pool_tag[pos] = id;
      pool_fill++;
      g.status = ST_STORED;
    end
    return g;
  endfunction

  // Random sizes lean toward values near pooled sizes and the miss floor.
  function automatic logic [SIZE_W-1:0] pick_amount();
    logic [SIZE_W-1:0] a;
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = SIZE_MAX;
      2: a = SIZE_W'({$urandom(), $urandom()});
      3: a = model_min_size + SIZE_W'($urandom_range(0, 2)) - 1;
      4, 5: begin
        if (pool_fill > 0) begin
          a = pool_sz[$urandom_range(0, pool_fill - 1)] + SIZE_W'($urandom_range(0, 2)) - 1;
        end else begin
          a = SIZE_W'($urandom_range(0, 4095));
        end
      end
      default: a = SIZE_W'($urandom_range(0, 4095));
    endcase
    return a;
  endfunction

  task automatic send_word(input op_t op, input logic [SIZE_W-1:0] amount,
                           input logic [ID_W-1:0] id, input logic typed,
                           input grant_t typed_grant);
    int     gap;
    grant_t g;
    gap = burst ? 0 : $urandom_range(0, 16);
    start <= 1'b1;
    in_cmd <= op;
    in_amount <= amount;
    in_buffer_id <= id;
    do @(posedge clk); while (busy);
    g = pool_apply(op, amount, id);
    pending_grants.push_back(typed ? typed_grant : g);
    words_sent++;
    // With no gap, start stays high for the next word.
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0 || busy);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_min_size(input logic [SIZE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MIN_NEW_SIZE;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    model_min_size = value;
    @(posedge clk);
  endtask

  task automatic check_min_size(input logic [SIZE_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MIN_NEW_SIZE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SIZE_W-1:0] !== want) begin
      $error("min_new_size readback: expected %0h, actual %0h", want, prdata[SIZE_W-1:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : watch_results
    grant_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_grants.size() == 0) begin
        $error("result word with nothing expected: status %0d size %0h id %0h",
               out_status, out_granted_size, out_granted_id);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        status_seen[out_status]++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_granted_size !== want.size) begin
          $error("granted_size: expected %0h, actual %0h", want.size, out_granted_size);
          errors++;
        end
        if (out_granted_id !== want.id) begin
          $error("granted_id: expected %0h, actual %0h", want.id, out_granted_id);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] setting;
    int                release_pct;
    op_t               op;

    errors = 0;
    words_sent = 0;
    pool_fill = 0;
    burst = 1'b0;
    model_min_size = MIN_NEW_SIZE_RESET;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (pool_sz[i]) begin
      pool_sz[i] = '0;
      pool_tag[i] = '0;
    end

    // Pool starts empty: three misses, sixteen releases, one dropped release, then takes
    // that exercise zero size, the largest size and the tie among equal sizes, a release and a miss.
    directed_plan = '{
      '{OP_ALLOC,   48'd0,    32'd0,        1'b1, '{ST_NEW, MIN_NEW_SIZE_RESET, 32'd0}},
      '{OP_ALLOC,   SIZE_MAX, 32'hFFFF_FFFF, 1'b1, '{ST_NEW, SIZE_MAX, 32'd0}},
      '{OP_ALLOC,   48'd100,  32'd7,        1'b1, '{ST_NEW, MIN_NEW_SIZE_RESET, 32'd0}},
      '{OP_RELEASE, 48'd500,  32'd10,       1'b1, '{ST_STORED, 48'd0, 32'd0}},
      '{OP_RELEASE, 48'd0,    32'hFFFF_FFFF, 1'b1, '{ST_STORED, 48'd0, 32'd0}},
      '{OP_RELEASE, SIZE_MAX, 32'd0,        1'b1, '{ST_STORED, 48'd0, 32'd0}},
      '{OP_RELEASE, 48'd500,  32'd11,       1'b0, '0},
      '{OP_RELEASE, 48'd300,  32'd20,       1'b0, '0},
      '{OP_RELEASE, 48'd700,  32'd21,       1'b0, '0},
      '{OP_RELEASE, 48'd100,  32'd22,       1'b0, '0},
      '{OP_RELEASE, 48'd900,  32'd23,       1'b0, '0},
      '{OP_RELEASE, 48'd200,  32'd24,       1'b0, '0},
      '{OP_RELEASE, 48'd800,  32'd25,       1'b0, '0},
      '{OP_RELEASE, 48'd400,  32'd26,       1'b0, '0},
      '{OP_RELEASE, 48'd600,  32'd27,       1'b0, '0},
      '{OP_RELEASE, 48'd1000, 32'd28,       1'b0, '0},
      '{OP_RELEASE, 48'd150,  32'd29,       1'b0, '0},
      '{OP_RELEASE, 48'd250,  32'd30,       1'b0, '0},
      '{OP_RELEASE, 48'd350,  32'd31,       1'b0, '0},
      '{OP_RELEASE, 48'd42,   32'd77,       1'b1, '{ST_DROPPED, 48'd0, 32'd0}},
      '{OP_ALLOC,   48'd500,  32'd0,        1'b1, '{ST_REUSED, 48'd500, 32'd10}},
      '{OP_ALLOC,   48'd0,    32'd99,       1'b1, '{ST_REUSED, 48'd0, 32'hFFFF_FFFF}},
      '{OP_ALLOC,   SIZE_MAX, 32'd0,        1'b1, '{ST_REUSED, SIZE_MAX, 32'd0}},
      '{OP_RELEASE, 48'd450,  32'd40,       1'b0, '0},
      '{OP_ALLOC,   48'd2000, 32'd0,        1'b1, '{ST_NEW, MIN_NEW_SIZE_RESET, 32'd0}}
    };

    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= 1'b0;
    in_amount <= '0;
    in_buffer_id <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_min_size(MIN_NEW_SIZE_RESET);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_word(directed_plan[r].op, directed_plan[r].amount, directed_plan[r].id,
                directed_plan[r].typed, directed_plan[r].grant);
    end

    // Each phase waits for the pool to settle before moving the miss floor.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: setting = '0;
        1: setting = SIZE_MAX;
        2: setting = SIZE_W'(1500);
        3: setting = SIZE_W'({$urandom(), $urandom()});
        default: setting = MIN_NEW_SIZE_RESET;
      endcase
      wait_idle();
      write_min_size(setting);
      check_min_size(setting);
      release_pct = 50;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0: release_pct = 20;
            1: release_pct = 50;
            default: release_pct = 85;
          endcase
          burst = ($urandom_range(0, 3) == 0);
        end
        op = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_ALLOC;
        send_word(op, pick_amount(), $urandom(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Sent %0d request words over %0d miss-floor settings plus reset default.",
             words_sent, RANDOM_PHASES);
    $display("Results: %0d reused, %0d new, %0d stored, %0d dropped.",
             status_seen[ST_REUSED], status_seen[ST_NEW], status_seen[ST_STORED],
             status_seen[ST_DROPPED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bfp_pkg.sv
hw/rtl/bfp_front.sv
hw/rtl/bfp_back.sv
hw/rtl/best_fit_buffer_pool.sv
test/testbench.sv
